// ===== hw/rtl/smpq_pkg.sv =====
`default_nettype none

package smpq_pkg;

	// queue geometry
	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// fixed field widths of the request and response
	localparam int VALUE_W = 32;
	localparam int REQ_PRIO_W = 8;
	localparam int OCC_W   = 5;

	// request kinds
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one stored entry
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_BITS-1:0]      prio;
	} entry_t;

	// control broadcast to every cell
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ins;
	} smpq_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smpq_if.sv =====
`default_nettype none

// request channel
interface smpq_in_if
	import smpq_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [VALUE_W-1:0] value;
	logic [REQ_PRIO_W-1:0]     priority_req;

	modport source (output valid, kind, value, priority_req, input ready);
	modport sink   (input valid, kind, value, priority_req, output ready);
endinterface

// response channel
interface smpq_out_if
	import smpq_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] popped_value;
	logic [1:0]                status;
	logic [OCC_W-1:0]          occupancy;

	modport source (output valid, popped_value, status, occupancy, input ready);
	modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stable_min_priority_queue_top.sv =====
// channel | dir | signals                                   | accepted when
// req     | in  | kind, value, priority_req                 | req.valid && req.ready
// rsp     | out | popped_value, status, occupancy           | rsp.valid && rsp.ready
//
// every request is taken by the row of cells when it fires; its response sits
// in the output register from the next cycle on
// a new request is taken while the output register is empty or being drained
// reset empties the queue at once; no clearing pass
// a stalled response holds the request side until it is taken
`default_nettype none

module stable_min_priority_queue_top
	import smpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	smpq_in_if.sink   req,
	smpq_out_if.source rsp
);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	logic signed [VALUE_W-1:0] rsp_value_q;
	status_t          rsp_status_q;
	logic [OCC_W-1:0] rsp_occ_q;

	logic      fire;
	logic      is_pop;
	logic      full;
	logic      empty;
	smpq_ctl_t ctl;
	entry_t    cell_entry [DEPTH];
	logic      cell_stay  [DEPTH];
	logic [CNT_W-1:0] count_next;
	status_t   status_next;

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_pop    = (req.kind == KIND_POP);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// control broadcast to the cells
	always_comb begin
		ctl.push       = fire && !is_pop && !full;
		ctl.pop        = fire && is_pop && !empty;
		ctl.ins.value  = req.value;
		ctl.ins.prio   = PRIO_BITS'(req.priority_req);
		count_next     = count_q;
		status_next    = ST_OK;
		if (ctl.push) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_next = count_q - CNT_W'(1);
		end
		if (is_pop && empty) begin
			status_next = ST_EMPTY;
		end else if (!is_pop && full) begin
			status_next = ST_FULL;
		end
	end

	// row of cells, kept sorted by priority, oldest first among equals
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   prev_stay;
		entry_t prev_entry;
		entry_t next_entry;

		if (i == 0) begin : g_head
			assign prev_stay  = 1'b1;
			assign prev_entry = '0;
		end else begin : g_body
			assign prev_stay  = cell_stay[i-1];
			assign prev_entry = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = cell_entry[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.self_valid (CNT_W'(i) < count_q),
			.prev_entry (prev_entry),
			.prev_stay  (prev_stay),
			.next_entry (next_entry),
			.entry      (cell_entry[i]),
			.stay       (cell_stay[i])
		);
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_value_q  <= ctl.pop ? cell_entry[0].value : '0;
			rsp_status_q <= status_next;
			rsp_occ_q    <= OCC_W'(count_next);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.occupancy    = rsp_occ_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_pop && full |=> rsp.valid && rsp.status == ST_FULL && full)
		else $error("push on full queue not dropped");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_pop && !empty |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not lower the count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.popped_value == '0 && empty)
		else $error("empty pop response carries data");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/smpq_cell.sv =====
`default_nettype none

module smpq_cell
	import smpq_pkg::*;
(
	input  wire logic      clk,
	input  wire smpq_ctl_t ctl,
	input  wire logic      self_valid,
	input  wire entry_t    prev_entry,
	input  wire logic      prev_stay,
	input  wire entry_t    next_entry,
	output entry_t         entry,
	output logic           stay
);

	entry_t entry_q;

	// entry keeps its place on a push when it ranks at or ahead of the new one
	assign stay  = self_valid && (entry_q.prio <= ctl.ins.prio);
	assign entry = entry_q;

	// push: insert here or shift right; pop: shift left
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (!stay) begin
				entry_q <= prev_stay ? ctl.ins : prev_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

`default_nettype wire
